### sv/adm_pkg.sv
// adm_pkg: widths and constants shared by the accelerometer magnitude block.
// No dependencies; imported by adm_div, adm_isqrt and accel_dynamic_magnitude.

package adm_pkg;

    // number of samples averaged into the offsets after reset (1 .. 1024)
    localparam int CALIB_COUNT = 100;

    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int SMP_W     = 16;               // raw sample
    localparam int FRAC_W    = 4;                // fraction bits of offsets
    localparam int SUM_W     = 26;               // signed per-axis sum
    localparam int CNT_W     = $clog2(CALIB_COUNT + 1);
    localparam int OFS_W     = 21;               // signed offset, 4 fraction bits
    localparam int DIFF_W    = 22;               // signed sample*16 - offset
    localparam int MAG_W     = 21;               // root / abs deviation
    localparam int SQ_W      = 2 * MAG_W;        // sum of squares
    localparam int DIV_NUM_W = 30;               // |sum|*16 + CALIB_COUNT/2
    localparam int DIV_STEP_W = 2;
    localparam int SQRT_STEP_W = $clog2(MAG_W);

    // division by CALIB_COUNT: q = (n * DIV_RECIP) >> DIV_SHIFT, exact for any n below
    // 2**DIV_NUM_W; the dividend is split into two halves for the partial products
    localparam int DIV_PART_W = DIV_NUM_W / 2;
    localparam int DIV_SHIFT  = DIV_NUM_W + $clog2(CALIB_COUNT);
    localparam int RECIP_W    = DIV_NUM_W + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CALIB_COUNT - 1)) / 64'(CALIB_COUNT));
    localparam int DIV_MUL_W  = DIV_PART_W + RECIP_W;   // one partial product
    localparam int DIV_ACC_W  = DIV_NUM_W + RECIP_W;    // full product

endpackage

### sv/adm_div.sv
// adm_div: division by CALIB_COUNT through a constant reciprocal, one half-width
// partial product per cycle. Depends on adm_pkg.

module adm_div
    import adm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    localparam logic [DIV_STEP_W-1:0] STEP_LO  = DIV_STEP_W'(0);   // low half product
    localparam logic [DIV_STEP_W-1:0] STEP_HI  = DIV_STEP_W'(1);   // high half product
    localparam logic [DIV_STEP_W-1:0] STEP_SUM = DIV_STEP_W'(2);   // add shifted high half

    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_MUL_W-1:0]  prod_reg;
    logic [DIV_ACC_W-1:0]  acc_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIV_PART_W-1:0] part;

    // dividend half for this step
    always_comb
    begin
        part = (step_reg == STEP_LO) ? num_reg[DIV_PART_W-1:0]
                                     : num_reg[DIV_NUM_W-1 -: DIV_PART_W];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LO;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_SUM)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_LO:
                begin
                    prod_reg <= part * DIV_RECIP;
                end
                STEP_HI:
                begin
                    acc_reg  <= DIV_ACC_W'(prod_reg);
                    prod_reg <= part * DIV_RECIP;
                end
                STEP_SUM:
                begin
                    acc_reg <= acc_reg + {prod_reg, {DIV_PART_W{1'b0}}};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = DIV_NUM_W'(acc_reg >> DIV_SHIFT);

endmodule

### sv/adm_isqrt.sv
// adm_isqrt: digit-by-digit floored square root, one root bit per cycle.
// Depends on adm_pkg.

module adm_isqrt
    import adm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   value,
    output logic              done,
    output logic [MAG_W-1:0]  root
);

    localparam int REM_W = MAG_W + 3;

    logic [SQ_W-1:0]        val_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [MAG_W-1:0]       root_reg;
    logic [SQRT_STEP_W-1:0] step_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [REM_W-1:0]       rem_shift;
    logic [REM_W-1:0]       trial;
    logic                   fits;

    // bring down two bits, try root*4+1
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], val_reg[SQ_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SQRT_STEP_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[MAG_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### sv/accel_dynamic_magnitude.sv
// Offset-calibrated magnitude of a three-axis accelerometer sample (adm_pkg, adm_div, adm_isqrt).
// Calibration requests: sums are updated on acceptance; the last one adds three reciprocal
// divisions, one per axis, to form the offsets.
// Measurement requests: 3 shared multiply/accumulate passes and the 21-step root unit, then
// ST_FINISH hands the result to the output register. New samples are taken only in ST_IDLE.
// Reset (rst_n, async, active low) clears sums, count, offsets and the output valid.

module accel_dynamic_magnitude
    import adm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // x_sample[15:0], y_sample[31:16], z_sample[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // magnitude[20:0], zero pad[23:21]
    output logic        m_axis_tuser    // calibrating
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV_START = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
    localparam logic [2:0] ST_MUL       = 3'd3;
    localparam logic [2:0] ST_ACC       = 3'd4;
    localparam logic [2:0] ST_SQRT_WAIT = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    logic [2:0]              state_reg;
    logic [AXIS_W-1:0]       axis_reg;
    logic                    calibrated_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic signed [OFS_W-1:0] ofs_reg [AXES];
    logic [SMP_W-1:0]        smp_reg [AXES];
    logic [SQ_W-1:0]         prod_reg;
    logic [SQ_W-1:0]         acc_reg;
    logic                    res_calib_reg;
    logic [MAG_W-1:0]        res_mag_reg;
    logic                    out_valid_reg;
    logic                    out_calib_reg;
    logic [MAG_W-1:0]        out_mag_reg;

    logic                    in_accept;
    logic [SMP_W-1:0]        in_smp [AXES];
    logic [SUM_W-1:0]        sum_abs;
    logic [DIV_NUM_W-1:0]    div_num;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_NUM_W-1:0]    div_quo;
    logic [OFS_W-1:0]        ofs_mag;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]        diff_abs;
    logic [SQ_W-1:0]         acc_sum;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [MAG_W-1:0]        sqrt_root;
    logic                    out_free;

    assign in_smp[0] = s_axis_tdata[15:0];
    assign in_smp[1] = s_axis_tdata[31:16];
    assign in_smp[2] = s_axis_tdata[47:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // divider operand: |sum| * 16 rounded half away from zero
    always_comb
    begin
        sum_abs = sum_reg[axis_reg][SUM_W-1] ? SUM_W'(-sum_reg[axis_reg])
                                             : SUM_W'(sum_reg[axis_reg]);
        div_num = {sum_abs, {FRAC_W{1'b0}}} + DIV_NUM_W'(CALIB_COUNT / 2);
        ofs_mag = div_quo[OFS_W-1:0];
    end

    assign div_start = (state_reg == ST_DIV_START);

    adm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .done  (div_done),
        .quo   (div_quo)
    );

    // deviation of the selected axis and its magnitude
    always_comb
    begin
        diff = DIFF_W'(signed'({smp_reg[axis_reg], {FRAC_W{1'b0}}}))
             - DIFF_W'(ofs_reg[axis_reg]);
        diff_abs = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        acc_sum  = acc_reg + prod_reg;
    end

    assign sqrt_start = (state_reg == ST_ACC) && (axis_reg == LAST_AXIS);

    adm_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (acc_sum),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // sequencer and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= '0;
            calibrated_reg <= 1'b0;
            count_reg      <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i] <= '0;
                ofs_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= '0;
                    if (in_accept)
                    begin
                        if (!calibrated_reg)
                        begin
                            for (int i = 0; i < AXES; i++)
                            begin
                                sum_reg[i] <= sum_reg[i]
                                            + SUM_W'(signed'(in_smp[i]));
                            end
                            count_reg <= count_reg + 1'b1;
                            if (count_reg == CNT_W'(CALIB_COUNT - 1))
                            begin
                                state_reg <= ST_DIV_START;
                            end
                            else
                            begin
                                state_reg <= ST_FINISH;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        ofs_reg[axis_reg] <= sum_reg[axis_reg][SUM_W-1]
                                           ? signed'(-ofs_mag) : signed'(ofs_mag);
                        if (axis_reg == LAST_AXIS)
                        begin
                            calibrated_reg <= 1'b1;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (axis_reg == LAST_AXIS)
                    begin
                        state_reg <= ST_SQRT_WAIT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // sample capture, shared multiplier, accumulator, staged result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                smp_reg[i] <= in_smp[i];
            end
            acc_reg       <= '0;
            res_calib_reg <= !calibrated_reg;
            res_mag_reg   <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= diff_abs * diff_abs;
        end
        if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_sum;
        end
        if ((state_reg == ST_SQRT_WAIT) && sqrt_done)
        begin
            res_mag_reg <= sqrt_root;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_calib_reg <= res_calib_reg;
            out_mag_reg   <= res_mag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 24'(out_mag_reg);
    assign m_axis_tuser  = out_calib_reg;

endmodule

### sim/tb_accel_dynamic_magnitude.sv
// Self-checking testbench for accel_dynamic_magnitude: offset calibration and magnitude results,
// with random idle cycles on both stream ports. Depends on adm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_accel_dynamic_magnitude
    import adm_pkg::*;
();

    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake before giving up
    localparam int LONG_HOLD   = 400;    // receiver hold-off used to back up the input

    typedef struct packed {
        logic signed [SMP_W-1:0] z;
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] x;
    } sample_t;

    typedef struct {
        logic             calibrating;
        logic [MAG_W-1:0] magnitude;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;     // x_sample[15:0], y_sample[31:16], z_sample[47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // magnitude[20:0], zero pad[23:21]
    logic        m_axis_tuser;     // calibrating

    accel_dynamic_magnitude dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state, mirrors the block's calibration registers
    logic signed [SUM_W-1:0] acc_x, acc_y, acc_z;
    logic [10:0]             calib_taken;
    logic signed [OFS_W-1:0] ofs_x, ofs_y, ofs_z;
    logic                    cal_done;

    sample_t sample_queue[$];       // samples waiting to be offered
    result_t expected_results[$];   // predicted results, oldest first

    int send_idle_pct;
    int recv_idle_pct;
    int items_queued;
    int results_checked;
    int samples_accepted;
    int calib_results;
    int max_mag_seen;
    int err_count;
    int quiet_cycles;
    int hold_requests;
    int holds_started;
    int recv_hold_left;
    int ctr_x, ctr_y, ctr_z;        // offsets in raw LSB, centers for small deviations
    logic req_taken;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 20)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Mean with 4 fraction bits, rounded to nearest with ties away from zero
    function automatic logic signed [OFS_W-1:0] offset_from_sum(input logic signed [SUM_W-1:0] s);
        longint num;
        longint q;
        num = longint'(s) * 16;
        if (num >= 0)
            q = (num + CALIB_COUNT / 2) / CALIB_COUNT;
        else
            q = -((-num + CALIB_COUNT / 2) / CALIB_COUNT);
        return q[OFS_W-1:0];
    endfunction

    // Floored square root, decided one result bit at a time from the top
    function automatic logic [MAG_W-1:0] floor_root(input longint unsigned v);
        logic [MAG_W-1:0]  r;
        longint unsigned   trial;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            r[b]  = 1'b1;
            trial = {43'd0, r};
            if (trial * trial > v)
                r[b] = 1'b0;
        end
        return r;
    endfunction

    // Expected result for one accepted sample; advances the calibration state
    function automatic result_t predict_result(input sample_t s);
        result_t r;
        longint  dx, dy, dz;
        longint unsigned energy;
        if (!cal_done)
        begin
            acc_x = acc_x + {{(SUM_W - SMP_W){s.x[SMP_W-1]}}, s.x};
            acc_y = acc_y + {{(SUM_W - SMP_W){s.y[SMP_W-1]}}, s.y};
            acc_z = acc_z + {{(SUM_W - SMP_W){s.z[SMP_W-1]}}, s.z};
            calib_taken = calib_taken + 11'd1;
            if (calib_taken >= CALIB_COUNT)
            begin
                ofs_x    = offset_from_sum(acc_x);
                ofs_y    = offset_from_sum(acc_y);
                ofs_z    = offset_from_sum(acc_z);
                cal_done = 1'b1;
            end
            r.calibrating = 1'b1;
            r.magnitude   = '0;
        end
        else
        begin
            dx = longint'(s.x) * 16 - longint'(ofs_x);
            dy = longint'(s.y) * 16 - longint'(ofs_y);
            dz = longint'(s.z) * 16 - longint'(ofs_z);
            energy = dx * dx + dy * dy + dz * dz;
            r.calibrating = 1'b0;
            r.magnitude   = floor_root(energy);
        end
        return r;
    endfunction

    task automatic push_sample(input int x, input int y, input int z);
        sample_t s;
        s.x = x[15:0];
        s.y = y[15:0];
        s.z = z[15:0];
        sample_queue.push_back(s);
        items_queued++;
    endtask

    // Mix of full-range, near-offset (small roots), corner and moderate samples
    task automatic push_random();
        int pick;
        int v[3];
        int centers[3];
        int corners[4];
        corners = '{-32768, 32767, 0, -1};
        centers = '{ctr_x, ctr_y, ctr_z};
        pick = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            if (pick <= 3)
                v[a] = int'($urandom_range(0, 65535)) - 32768;
            else if (pick <= 6)
                v[a] = centers[a] + int'($urandom_range(0, 128)) - 64;
            else if (pick == 7)
                v[a] = corners[$urandom_range(0, 3)];
            else
                v[a] = centers[a] + int'($urandom_range(0, 8192)) - 4096;
        end
        push_sample(v[0], v[1], v[2]);
    endtask

    // Wait until every queued sample has produced its result; returns at a rising edge
    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_checked != items_queued);
        @(posedge clk);
    endtask

    // Monitor: predict on input requests, check output requests, watchdog
    always @(posedge clk)
    begin : monitor
        sample_t s;
        result_t want;
        logic    out_fire;
        req_taken = 1'b0;
        if (rst_n)
        begin
            req_taken = s_axis_tvalid && s_axis_tready;
            out_fire  = m_axis_tvalid && m_axis_tready;

            if (out_fire)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result mag=%0d cal=%0b",
                                              m_axis_tdata[MAG_W-1:0], m_axis_tuser));
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_axis_tuser !== want.calibrating)
                        report_mismatch($sformatf("result %0d: calibrating %0b, expected %0b",
                                                  results_checked, m_axis_tuser,
                                                  want.calibrating));
                    if (m_axis_tdata[MAG_W-1:0] !== want.magnitude)
                        report_mismatch($sformatf("result %0d: magnitude %0d, expected %0d",
                                                  results_checked, m_axis_tdata[MAG_W-1:0],
                                                  want.magnitude));
                    if (m_axis_tdata[23:MAG_W] !== '0)
                        report_mismatch($sformatf("result %0d: pad bits %b not zero",
                                                  results_checked, m_axis_tdata[23:MAG_W]));
                    if (!want.calibrating && int'(want.magnitude) > max_mag_seen)
                        max_mag_seen = int'(want.magnitude);
                    if (want.calibrating)
                        calib_results++;
                end
            end

            if (req_taken)
            begin
                s.x = s_axis_tdata[15:0];
                s.y = s_axis_tdata[31:16];
                s.z = s_axis_tdata[47:32];
                expected_results.push_back(predict_result(s));
                samples_accepted++;
            end

            // watchdog
            if (req_taken || out_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet_cycles, expected_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Sender: offers the next sample once the current one is taken
    always @(negedge clk)
    begin : drive_samples
        sample_t s;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || req_taken)
        begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s = sample_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {s.z, s.y, s.x};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random ready, plus a long hold-off on request
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (holds_started != hold_requests)
        begin
            holds_started++;
            recv_hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (recv_hold_left > 0)
        begin
            recv_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        m_axis_tready    = 1'b0;
        acc_x            = '0;
        acc_y            = '0;
        acc_z            = '0;
        calib_taken      = '0;
        ofs_x            = '0;
        ofs_y            = '0;
        ofs_z            = '0;
        cal_done         = 1'b0;
        req_taken        = 1'b0;
        items_queued     = 0;
        results_checked  = 0;
        samples_accepted = 0;
        calib_results    = 0;
        max_mag_seen     = 0;
        err_count        = 0;
        quiet_cycles     = 0;
        hold_requests    = 0;
        holds_started    = 0;
        recv_hold_left   = 0;
        ctr_x            = 0;
        ctr_y            = 0;
        ctr_z            = 0;
        send_idle_pct    = 28;
        recv_idle_pct    = 74;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Calibration: corners first, then X pulled low and Y high for large offsets
        push_sample(32767, -32768, 0);
        push_sample(-32768, 32767, -1);
        push_sample(-32768, 32767, 32767);
        for (int k = 0; k < CALIB_COUNT - 3; k++)
            push_sample(-32768 + int'($urandom_range(0, 4000)),
                        32767 - int'($urandom_range(0, 4000)),
                        int'($urandom_range(0, 65535)) - 32768);
        wait_drained();

        ctr_x = int'(ofs_x) / 16;
        ctr_y = int'(ofs_y) / 16;
        ctr_z = int'(ofs_z) / 16;

        // Directed measurements: full scale, zero, at the offset, alternating bits
        push_sample(32767, -32768, 32767);
        push_sample(32767, -32768, -32768);
        push_sample(-32768, 32767, 0);
        push_sample(0, 0, 0);
        push_sample(-1, -1, -1);
        push_sample(32767, 32767, 32767);
        push_sample(-32768, -32768, -32768);
        push_sample(ctr_x, ctr_y, ctr_z);
        push_sample(ctr_x + 1, ctr_y, ctr_z);
        push_sample(ctr_x, ctr_y - 1, ctr_z + 1);
        push_sample(21845, -21846, 21845);
        push_sample(-21846, 21845, -21846);

        for (int k = 0; k < 300; k++)
            push_random();
        wait_drained();

        // Receiver mostly ready, sender sparse
        send_idle_pct = 74;
        recv_idle_pct = 28;
        for (int k = 0; k < 400; k++)
            push_random();
        wait_drained();

        // Back to back, with a long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 250; k++)
            push_random();
        hold_requests++;
        wait_drained();
        for (int k = 0; k < 190; k++)
            push_random();
        wait_drained();

        repeat (150) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Covered %0d samples: %0d during calibration, %0d measured, peak magnitude %0d",
                 samples_accepted, calib_results, results_checked - calib_results, max_mag_seen);
        $display("Offsets (1/16 LSB): x=%0d y=%0d z=%0d; %0d mismatches",
                 ofs_x, ofs_y, ofs_z, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
